// ===== hdl/vrr_pkg.sv =====
package vrr_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int STEP_W     = 19;
    localparam int COEF_W     = 18;
    localparam int LO_W       = 18;
    localparam int ACC_W      = 38;
    localparam int PAIR_W     = 17;
    localparam int GUARD      = 7;
    localparam int MAX_OUT    = 8;
    localparam int NUM_TAPS   = 6;
    localparam int CNT_W      = 3;
    localparam int STEP_RESET = 65536;

    typedef enum logic [1:0] {
        MUL_LO,
        MUL_HI,
        MUL_COEF
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ADD,
        ACC_SAVE_LO,
        ACC_HORNER
    } acc_op_t;

    typedef struct packed {
        logic       wr_sample;
        logic       clr_wr;
        logic       tap_start;
        logic       rd;
        logic       tap_shift;
        logic       mul_en;
        mul_sel_t   mul_sel;
        acc_op_t    acc_op;
        logic [2:0] cidx;
        logic [1:0] pair;
        logic       round;
        logic       advance;
        logic       push;
        logic       last;
    } vrr_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic avail;
        logic slot_free;
    } vrr_status_t;

    // Polynomial coefficient cidx is a weighted sum of the three tap pairs.
    function automatic logic signed [COEF_W-1:0] coef_value(input logic [2:0] cidx,
                                                            input logic [1:0] pair);
        logic signed [COEF_W-1:0] v;
        v = '0;
        case ({cidx, pair})
            5'b000_00: v = 18'sd111899;
            5'b000_01: v = 18'sd18974;
            5'b000_10: v = 18'sd199;
            5'b001_00: v = 18'sd93931;
            5'b001_01: v = 18'sd53613;
            5'b001_10: v = 18'sd1475;
            5'b010_00: v = -18'sd56888;
            5'b010_01: v = 18'sd52563;
            5'b010_10: v = 18'sd4324;
            5'b011_00: v = -18'sd65831;
            5'b011_01: v = 18'sd11070;
            5'b011_10: v = 18'sd6524;
            5'b100_00: v = 18'sd10923;
            5'b100_01: v = -18'sd16385;
            5'b100_10: v = 18'sd5462;
            5'b101_00: v = 18'sd21888;
            5'b101_01: v = -18'sd10944;
            5'b101_10: v = 18'sd2189;
            default:   v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/vrr_ctrl.sv =====
module vrr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  vrr_pkg::vrr_status_t st,
    output vrr_pkg::vrr_cmd_t    cmd
);
    import vrr_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_CHECK = 8'b0000_0100,
        S_TAPS  = 8'b0000_1000,
        S_C5    = 8'b0001_0000,
        S_HORN  = 8'b0010_0000,
        S_ROUND = 8'b0100_0000,
        S_PUSH  = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [2:0]       k_reg, k_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             last_c;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            k_reg     <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
        end
    end

    assign last_c = !st.avail || (n_reg == CNT_W'(MAX_OUT - 1));

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (st.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.wr_sample = 1'b1;
                    n_next        = '0;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (st.avail)
                begin
                    cmd.tap_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_TAPS;
                end
                else
                    state_next = S_IDLE;
            end
            S_TAPS:
            begin
                cmd.rd        = (cnt_reg < CNT_W'(NUM_TAPS));
                cmd.tap_shift = (cnt_reg != '0);
                if (cnt_reg == CNT_W'(NUM_TAPS))
                begin
                    cnt_next   = '0;
                    state_next = S_C5;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_C5:
            begin
                cmd.cidx    = 3'd5;
                cmd.pair    = cnt_reg[1:0];
                cmd.mul_sel = MUL_COEF;
                cmd.mul_en  = (cnt_reg < 3'd3);
                cmd.acc_op  = (cnt_reg == '0) ? ACC_CLEAR : ACC_ADD;
                if (cnt_reg == 3'd3)
                begin
                    cnt_next   = '0;
                    k_next     = 3'd4;
                    state_next = S_HORN;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_HORN:
            begin
                cmd.cidx = k_reg;
                cnt_next = cnt_reg + 1'b1;
                case (cnt_reg)
                    3'd0:
                    begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = MUL_LO;
                    end
                    3'd1:
                    begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = MUL_HI;
                        cmd.acc_op  = ACC_SAVE_LO;
                    end
                    3'd2:
                    begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = MUL_COEF;
                        cmd.pair    = 2'd0;
                        cmd.acc_op  = ACC_HORNER;
                    end
                    3'd3:
                    begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = MUL_COEF;
                        cmd.pair    = 2'd1;
                        cmd.acc_op  = ACC_ADD;
                    end
                    3'd4:
                    begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = MUL_COEF;
                        cmd.pair    = 2'd2;
                        cmd.acc_op  = ACC_ADD;
                    end
                    default:
                    begin
                        cmd.acc_op = ACC_ADD;
                        cnt_next   = '0;
                        if (k_reg == '0)
                            state_next = S_ROUND;
                        else
                            k_next = k_reg - 1'b1;
                    end
                endcase
            end
            S_ROUND:
            begin
                cmd.round   = 1'b1;
                cmd.advance = 1'b1;
                state_next  = S_PUSH;
            end
            S_PUSH:
            begin
                if (st.slot_free)
                begin
                    cmd.push = 1'b1;
                    cmd.last = last_c;
                    n_next   = n_reg + 1'b1;
                    if (last_c)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.tap_start = 1'b1;
                        cnt_next      = '0;
                        state_next    = S_TAPS;
                    end
                end
            end
            default:
                state_next = S_CLEAR;
        endcase
    end

endmodule

// ===== hdl/vrr_datapath.sv =====
module vrr_datapath #(
    parameter int RING_DEPTH    = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vrr_pkg::vrr_cmd_t                   cmd,
    output vrr_pkg::vrr_status_t                st,
    input  logic signed [vrr_pkg::SAMPLE_W-1:0] in_sample,
    input  logic [vrr_pkg::STEP_W-1:0]          read_step,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [vrr_pkg::SAMPLE_W-1:0] out_sample,
    output logic                                run_last
);
    import vrr_pkg::*;

    localparam int AW     = $clog2(RING_DEPTH);
    localparam int POS_W  = AW + FRACTION_BITS;
    localparam int CW     = (POS_W + 1 > STEP_W + 1) ? POS_W + 1 : STEP_W + 1;
    localparam int OA_W   = ACC_W - LO_W;
    localparam int MB_W   = (FRACTION_BITS > COEF_W) ? FRACTION_BITS : COEF_W;
    localparam int PROD_W = OA_W + MB_W;
    localparam int FULL_W = PROD_W + LO_W;
    localparam logic [CW-1:0] SPAN = CW'(RING_DEPTH) << FRACTION_BITS;
    localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);

    logic [SAMPLE_W-1:0]         ring_mem [RING_DEPTH];
    logic [SAMPLE_W-1:0]         rd_data_reg;
    logic signed [SAMPLE_W-1:0]  tap_reg [NUM_TAPS];

    logic [AW-1:0]               wp_reg, rw_reg, tap_addr_reg;
    logic [FRACTION_BITS-1:0]    rf_reg;

    logic signed [PROD_W-1:0]    prod_reg, lo_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [SAMPLE_W-1:0]  res_reg;
    logic                        out_valid_reg, out_last_reg;
    logic signed [SAMPLE_W-1:0]  out_sample_reg;

    logic                        we;
    logic [AW-1:0]               waddr;
    logic [SAMPLE_W-1:0]         wdata;

    logic [AW-1:0]               tw;
    logic [CW-1:0]               pos_ext, tgt_ext, diff, room, npos, npos_w;
    logic signed [FRACTION_BITS-1:0] z;
    logic signed [PAIR_W-1:0]    pair_val;
    logic signed [OA_W-1:0]      mul_a;
    logic signed [MB_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]    mul_p;
    logic signed [FULL_W-1:0]    full, full_sh;
    logic signed [ACC_W-1:0]     bias, rsum;
    logic signed [OA_W-1:0]      rq;
    logic signed [SAMPLE_W-1:0]  sat;

    function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + 1'b1;
    endfunction

    // Ring memory: one write port, one registered read port.
    assign we    = cmd.wr_sample | cmd.clr_wr;
    assign waddr = cmd.wr_sample ? wp_reg : tap_addr_reg;
    assign wdata = cmd.wr_sample ? in_sample : '0;

    always_ff @(posedge clk) begin
        if (we)
            ring_mem[waddr] <= wdata;
        if (cmd.rd)
            rd_data_reg <= ring_mem[tap_addr_reg];
    end

    // Position and addressing.
    assign tw      = (wp_reg >= AW'(GUARD)) ? wp_reg - AW'(GUARD)
                                            : wp_reg + AW'(RING_DEPTH - GUARD);
    assign pos_ext = CW'({rw_reg, rf_reg});
    assign tgt_ext = CW'({tw, {FRACTION_BITS{1'b0}}});
    assign diff    = tgt_ext - pos_ext;
    assign room    = (tgt_ext >= pos_ext) ? diff : diff + SPAN;
    assign npos    = pos_ext + CW'(read_step);
    assign npos_w  = (npos >= SPAN) ? npos - SPAN : npos;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rw_reg        <= '0;
            rf_reg        <= '0;
            tap_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_sample)
                wp_reg <= next_addr(wp_reg);
            if (cmd.tap_start)
                tap_addr_reg <= rw_reg;
            else if (cmd.rd || cmd.clr_wr)
                tap_addr_reg <= next_addr(tap_addr_reg);
            if (cmd.advance)
            begin
                rw_reg <= npos_w[FRACTION_BITS +: AW];
                rf_reg <= npos_w[FRACTION_BITS-1:0];
            end
            if (cmd.push)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Tap pairs and the shared multiplier.
    assign z = $signed({~rf_reg[FRACTION_BITS-1], rf_reg[FRACTION_BITS-2:0]});

    always_comb begin
        pair_val = '0;
        case (cmd.pair)
            2'd0: pair_val = cmd.cidx[0] ? PAIR_W'(tap_reg[3]) - PAIR_W'(tap_reg[2])
                                         : PAIR_W'(tap_reg[3]) + PAIR_W'(tap_reg[2]);
            2'd1: pair_val = cmd.cidx[0] ? PAIR_W'(tap_reg[4]) - PAIR_W'(tap_reg[1])
                                         : PAIR_W'(tap_reg[4]) + PAIR_W'(tap_reg[1]);
            2'd2: pair_val = cmd.cidx[0] ? PAIR_W'(tap_reg[5]) - PAIR_W'(tap_reg[0])
                                         : PAIR_W'(tap_reg[5]) + PAIR_W'(tap_reg[0]);
            default: pair_val = '0;
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_LO:
            begin
                mul_a = $signed({{(OA_W-LO_W){1'b0}}, acc_reg[LO_W-1:0]});
                mul_b = MB_W'(z);
            end
            MUL_HI:
            begin
                mul_a = $signed(acc_reg[ACC_W-1:LO_W]);
                mul_b = MB_W'(z);
            end
            MUL_COEF:
            begin
                mul_a = OA_W'(pair_val);
                mul_b = MB_W'(coef_value(cmd.cidx, cmd.pair));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Both operands are sign extended so the product keeps all of its bits.
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Horner step: full product of acc and z from two partial products, floored.
    assign full    = (FULL_W'(prod_reg) <<< LO_W) + FULL_W'(lo_reg);
    assign full_sh = full >>> FRACTION_BITS;

    // Round half away from zero, then saturate.
    assign bias = acc_reg[ACC_W-1] ? ACC_W'((1 << (LO_W - 1)) - 1) : ACC_W'(1 << (LO_W - 1));
    assign rsum = acc_reg + bias;
    assign rq   = $signed(rsum[ACC_W-1:LO_W]);

    always_comb begin
        if (rq > OA_W'(32767))
            sat = 16'sh7FFF;
        else if (rq < -OA_W'(32768))
            sat = -16'sh8000;
        else
            sat = rq[SAMPLE_W-1:0];
    end

    always_ff @(posedge clk) begin
        if (cmd.tap_shift)
        begin
            for (int i = 0; i < NUM_TAPS - 1; i++)
                tap_reg[i] <= tap_reg[i+1];
            tap_reg[NUM_TAPS-1] <= rd_data_reg;
        end
        if (cmd.mul_en)
            prod_reg <= mul_p;
        case (cmd.acc_op)
            ACC_CLEAR:   acc_reg <= '0;
            ACC_ADD:     acc_reg <= acc_reg + $signed(prod_reg[ACC_W-1:0]);
            ACC_SAVE_LO: lo_reg  <= prod_reg;
            ACC_HORNER:  acc_reg <= full_sh[ACC_W-1:0];
            default:     acc_reg <= acc_reg;
        endcase
        if (cmd.round)
            res_reg <= sat;
        if (cmd.push)
        begin
            out_sample_reg <= res_reg;
            out_last_reg   <= cmd.last;
        end
    end

    assign st.clr_last  = (tap_addr_reg == LAST_ADDR);
    assign st.avail     = (CW'(read_step) <= room);
    assign st.slot_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign run_last   = out_last_reg;

endmodule

// ===== hdl/variable_ratio_resampler.sv =====
// Variable ratio audio resampler with a six-point fifth-order polynomial interpolator.
//
// Input samples arrive on the in_valid/in_ready channel, one transaction per sample.
// Each sample is written into a ring; every output position that has fallen far
// enough behind the write position yields one interpolated sample on the
// out_valid/out_ready channel, at most eight per input. run_last marks the last
// output caused by an input. The read step is set through the APB port at address 0
// and must be written only while the block is idle; the block does not enforce this.
//
// One output is formed in order: the six taps are read through the single memory
// port, the one shared multiplier forms the coefficients and the Horner steps, the
// result is rounded, and then it is loaded into the output register.
// After reset the ring is cleared one entry a cycle, so in_ready stays low until
// every entry is cleared. A stalled receiver holds the result in the output register;
// the next result waits behind it, and a new input is taken after the last one.
module variable_ratio_resampler #(
    parameter int RING_DEPTH    = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [vrr_pkg::SAMPLE_W-1:0] in_sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [vrr_pkg::SAMPLE_W-1:0] out_sample,
    output logic                                run_last,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import vrr_pkg::*;

    logic [STEP_W-1:0] step_reg;
    vrr_cmd_t          cmd;
    vrr_status_t       st;
    logic              reg_hit;

    // The only register is decoded from paddr[2] alone: addresses 0 to 3 reach it, others read as zero.
    assign reg_hit = (paddr[2] == 1'b0);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? 32'(step_reg) : '0;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            step_reg <= STEP_W'(STEP_RESET);
        else if (psel && penable && pwrite && reg_hit)
            step_reg <= pwdata[STEP_W-1:0];
    end

    vrr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    vrr_datapath #(
        .RING_DEPTH    (RING_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .in_sample  (in_sample),
        .read_step  (step_reg),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .out_sample (out_sample),
        .run_last   (run_last)
    );

endmodule

// ===== hdl/vrr_checker.sv =====
module vrr_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [vrr_pkg::SAMPLE_W-1:0] out_sample,
    input logic                                run_last
);
    import vrr_pkg::*;

    logic [CNT_W-1:0] run_cnt_reg;

    // Outputs accepted since the last one that closed a run.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            run_cnt_reg <= '0;
        else if (out_valid && out_ready)
            run_cnt_reg <= run_last ? '0 : run_cnt_reg + 1'b1;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(run_last))
        else $error("stalled output changed");

    a_run_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && run_cnt_reg == CNT_W'(MAX_OUT - 1) |-> run_last)
        else $error("run longer than eight outputs");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while previous one is in work");

endmodule

bind variable_ratio_resampler vrr_checker u_vrr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .run_last   (run_last)
);
